>>> src/strs_pkg.sv
// ---------------------------------------------------------------------------
// strs_pkg
// Shared types and constants for the stepper trapezoid ramp sequencer.
// ---------------------------------------------------------------------------
package strs_pkg;

    localparam int TABLE_STEPS_DEF  = 256;
    localparam int HOMING_STEPS_DEF = 256;

    localparam int PERIOD_W = 16;
    localparam int ROT_W    = 16;
    localparam int CMD_W    = 2;
    localparam int PHASE_W  = 3;
    localparam int SEG_W    = ROT_W + 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [PERIOD_W-1:0] START_PERIOD_RST = 16'd2000;
    localparam logic [PERIOD_W-1:0] END_PERIOD_RST   = 16'd500;
    localparam logic [PERIOD_W-1:0] ACCEL_STEP_RST   = 16'd10;

    typedef enum logic [PHASE_W-1:0] {
        PH_IDLE   = 3'd0,
        PH_ACCEL  = 3'd1,
        PH_STEADY = 3'd2,
        PH_DECEL  = 3'd3,
        PH_HOMING = 3'd4
    } phase_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK   = 2'd0,
        CMD_START  = 2'd1,
        CMD_HOMING = 2'd2,
        CMD_STOP   = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_PERIOD = 2'd0,
        CFG_END_PERIOD   = 2'd1,
        CFG_ACCEL_STEP   = 2'd2,
        CFG_UNUSED       = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [PERIOD_W-1:0] start_period;
        logic [PERIOD_W-1:0] end_period;
        logic [PERIOD_W-1:0] accel_step;
    } cfg_t;

endpackage

>>> src/strs_period.sv
// ---------------------------------------------------------------------------
// strs_period
// Step period lookup: ramp period with clamp, steady and homing periods.
// ---------------------------------------------------------------------------
module strs_period #(
    parameter int TABLE_STEPS = strs_pkg::TABLE_STEPS_DEF,
    parameter int IDX_W       = 9
) (
    input  strs_pkg::phase_t                 phase,
    input  logic [IDX_W-1:0]                 idx,
    input  strs_pkg::cfg_t                   cfg,
    output logic [strs_pkg::PERIOD_W-1:0]    period
);

    logic [IDX_W-1:0]                      ramp_arg;
    logic [IDX_W+strs_pkg::PERIOD_W-1:0]   dec;
    logic [strs_pkg::PERIOD_W-1:0]         ramp_raw;
    logic [strs_pkg::PERIOD_W-1:0]         ramp;

    always_comb begin
        // deceleration walks the ramp backwards
        if (phase == strs_pkg::PH_DECEL) begin
            ramp_arg = IDX_W'(TABLE_STEPS - 1) - idx;
        end else begin
            ramp_arg = idx;
        end
        dec = ramp_arg * cfg.accel_step;
        if (dec >= (IDX_W+strs_pkg::PERIOD_W)'(cfg.start_period)) begin
            ramp_raw = '0;
        end else begin
            ramp_raw = cfg.start_period - dec[strs_pkg::PERIOD_W-1:0];
        end
        ramp = (ramp_raw < cfg.end_period) ? cfg.end_period : ramp_raw;

        case (phase)
            strs_pkg::PH_ACCEL:  period = ramp;
            strs_pkg::PH_DECEL:  period = ramp;
            strs_pkg::PH_STEADY: period = cfg.end_period;
            strs_pkg::PH_HOMING: period = cfg.start_period;
            default:             period = '0;
        endcase
    end

endmodule

>>> src/stepper_trapezoid_ramp_sequencer.sv
// ---------------------------------------------------------------------------
// stepper_trapezoid_ramp_sequencer
// Step pulse generator with a trapezoidal speed profile and homing run.
// ---------------------------------------------------------------------------
// Every input beat is one timer tick or command and yields exactly one result
// beat, registered in the cycle after acceptance. A new beat is taken every
// clock while the result side keeps up (s_ready is low only while a result
// is held by m_ready). The per-beat path is the step period lookup: one
// index by accel_step multiply, a subtract and clamp against end_period.
// A rotation run of n turns steps through 4n segments of TABLE_STEPS steps:
// accelerate, steady, decelerate. Configuration writes take effect at once
// and should be made while idle.
module stepper_trapezoid_ramp_sequencer #(
    parameter int TABLE_STEPS  = strs_pkg::TABLE_STEPS_DEF,
    parameter int HOMING_STEPS = strs_pkg::HOMING_STEPS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [strs_pkg::CMD_W-1:0]          s_command,
    input  logic [strs_pkg::ROT_W-1:0]          s_rotations,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_step_pulse,
    output logic                                m_enable_n,
    output logic [strs_pkg::PHASE_W-1:0]        m_phase,
    output logic                                m_accepted,
    input  logic                                cfg_wr_en,
    input  logic [strs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [strs_pkg::PERIOD_W-1:0]       cfg_wdata
);

    localparam int MAX_STEPS = (TABLE_STEPS > HOMING_STEPS) ? TABLE_STEPS : HOMING_STEPS;
    localparam int IDX_W     = $clog2(MAX_STEPS + 1);

    strs_pkg::cfg_t                          cfg_reg;
    strs_pkg::phase_t                        phase_reg, phase_next;
    logic [IDX_W-1:0]                        idx_reg, idx_next, idx_inc, limit;
    logic [strs_pkg::SEG_W-1:0]              seg_reg, seg_next, seg_dec;
    logic [strs_pkg::PERIOD_W-1:0]           tick_reg, tick_next;
    logic [strs_pkg::PERIOD_W-1:0]           period_reg, period_next, period_lut;
    logic                                    enable_reg, enable_next;
    logic                                    load_period;
    logic                                    pulse, taken;
    strs_pkg::cmd_t                          cmd;
    logic                                    s_beat;

    logic                                    m_valid_reg;
    logic                                    m_step_pulse_reg;
    logic                                    m_enable_n_reg;
    logic [strs_pkg::PHASE_W-1:0]            m_phase_reg;
    logic                                    m_accepted_reg;

    assign s_ready = !m_valid_reg || m_ready;
    assign s_beat  = s_valid && s_ready;
    assign cmd     = strs_pkg::cmd_t'(s_command);

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_period <= strs_pkg::START_PERIOD_RST;
            cfg_reg.end_period   <= strs_pkg::END_PERIOD_RST;
            cfg_reg.accel_step   <= strs_pkg::ACCEL_STEP_RST;
        end else if (cfg_wr_en) begin
            case (strs_pkg::cfg_idx_t'(cfg_index))
                strs_pkg::CFG_START_PERIOD: cfg_reg.start_period <= cfg_wdata;
                strs_pkg::CFG_END_PERIOD:   cfg_reg.end_period   <= cfg_wdata;
                strs_pkg::CFG_ACCEL_STEP:   cfg_reg.accel_step   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    strs_period #(
        .TABLE_STEPS (TABLE_STEPS),
        .IDX_W       (IDX_W)
    ) u_period (
        .phase  (phase_next),
        .idx    (idx_next),
        .cfg    (cfg_reg),
        .period (period_lut)
    );

    always_comb begin
        phase_next  = phase_reg;
        idx_next    = idx_reg;
        seg_next    = seg_reg;
        tick_next   = tick_reg;
        enable_next = enable_reg;
        load_period = 1'b0;
        pulse       = 1'b0;
        taken       = 1'b0;
        idx_inc     = idx_reg + 1'b1;
        seg_dec     = seg_reg - 1'b1;
        limit       = (phase_reg == strs_pkg::PH_HOMING) ? IDX_W'(HOMING_STEPS)
                                                         : IDX_W'(TABLE_STEPS);

        if (cmd == strs_pkg::CMD_STOP) begin
            phase_next  = strs_pkg::PH_IDLE;
            idx_next    = '0;
            seg_next    = '0;
            tick_next   = '0;
            enable_next = 1'b1;
        end else if (cmd == strs_pkg::CMD_START && phase_reg == strs_pkg::PH_IDLE
                     && s_rotations != '0) begin
            seg_next    = {s_rotations, 2'b00} - 1'b1;
            phase_next  = strs_pkg::PH_ACCEL;
            idx_next    = '0;
            tick_next   = '0;
            load_period = 1'b1;
            enable_next = 1'b0;
            taken       = 1'b1;
        end else if (cmd == strs_pkg::CMD_HOMING && phase_reg == strs_pkg::PH_IDLE) begin
            seg_next    = '0;
            phase_next  = strs_pkg::PH_HOMING;
            idx_next    = '0;
            tick_next   = '0;
            load_period = 1'b1;
            enable_next = 1'b0;
            taken       = 1'b1;
        end else if (phase_reg != strs_pkg::PH_IDLE) begin
            if (tick_reg != period_reg) begin
                tick_next = tick_reg + 1'b1;
            end else begin
                pulse     = 1'b1;
                tick_next = '0;
                if (idx_inc < limit) begin
                    idx_next    = idx_inc;
                    load_period = 1'b1;
                end else if (phase_reg == strs_pkg::PH_HOMING
                             || phase_reg == strs_pkg::PH_DECEL || seg_reg == '0) begin
                    phase_next  = strs_pkg::PH_IDLE;
                    idx_next    = '0;
                    seg_next    = '0;
                    enable_next = 1'b1;
                end else begin
                    // next segment: last one left is the deceleration
                    seg_next    = seg_dec;
                    phase_next  = (seg_dec == '0) ? strs_pkg::PH_DECEL : strs_pkg::PH_STEADY;
                    idx_next    = '0;
                    load_period = 1'b1;
                end
            end
        end
    end

    always_comb begin
        if (phase_next == strs_pkg::PH_IDLE) begin
            period_next = '0;
        end else if (load_period) begin
            period_next = period_lut;
        end else begin
            period_next = period_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= strs_pkg::PH_IDLE;
            idx_reg    <= '0;
            seg_reg    <= '0;
            tick_reg   <= '0;
            period_reg <= '0;
            enable_reg <= 1'b1;
        end else if (s_beat) begin
            phase_reg  <= phase_next;
            idx_reg    <= idx_next;
            seg_reg    <= seg_next;
            tick_reg   <= tick_next;
            period_reg <= period_next;
            enable_reg <= enable_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_beat) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_beat) begin
            m_step_pulse_reg <= pulse;
            m_enable_n_reg   <= enable_next;
            m_phase_reg      <= phase_next;
            m_accepted_reg   <= taken;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_step_pulse = m_step_pulse_reg;
    assign m_enable_n   = m_enable_n_reg;
    assign m_phase      = m_phase_reg;
    assign m_accepted   = m_accepted_reg;

endmodule

>>> src/strs_checker.sv
// ---------------------------------------------------------------------------
// strs_checker
// Port-level checks for the stepper trapezoid ramp sequencer.
// ---------------------------------------------------------------------------
module strs_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_valid,
    input logic                                s_ready,
    input logic [strs_pkg::CMD_W-1:0]          s_command,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic                                m_step_pulse,
    input logic                                m_enable_n,
    input logic [strs_pkg::PHASE_W-1:0]        m_phase,
    input logic                                m_accepted
);

    // a held result beat keeps its payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_step_pulse) && $stable(m_enable_n)
                                && $stable(m_phase) && $stable(m_accepted))
        else $error("result beat changed while stalled");

    // a taken start loads the first step only
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_accepted |-> !m_step_pulse && !m_enable_n
            && (m_phase == strs_pkg::PH_ACCEL || m_phase == strs_pkg::PH_HOMING))
        else $error("taken start with bad result");

    // idle always means the driver is off
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_phase == strs_pkg::PH_IDLE |-> m_enable_n)
        else $error("driver enabled while idle");

    // stop lands in idle on the next result
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_command == strs_pkg::CMD_STOP |=>
            m_valid && m_phase == strs_pkg::PH_IDLE && !m_step_pulse && !m_accepted)
        else $error("stop did not return to idle");

endmodule

bind stepper_trapezoid_ramp_sequencer strs_checker u_strs_checker (.*);

>>> dv/stepper_trapezoid_ramp_sequencer_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stepper_trapezoid_ramp_sequencer_tb
// Self-checking bench for the trapezoid ramp step sequencer. A short table of
// commands, some with hand-worked results, comes first. Random rotation and homing
// runs follow under several period settings, and they are checked beat by beat
// against an in-bench profile predictor. Both handshakes are throttled at
// random.
// ---------------------------------------------------------------------------
module stepper_trapezoid_ramp_sequencer_tb;
    import strs_pkg::*;

    localparam int          TABLE_STEPS  = TABLE_STEPS_DEF;
    localparam int          HOMING_STEPS = HOMING_STEPS_DEF;

    typedef struct packed {
        logic   pulse;
        logic   enable_n;
        phase_t phase;
        logic   accepted;
    } result_t;

    typedef struct {
        bit                  is_reg;
        cmd_t                cmd;
        cfg_idx_t            reg_idx;
        logic [ROT_W-1:0]    value;
        int unsigned         count;
        bit                  typed;
        result_t             want;
    } dir_row_t;

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 s_valid     = 1'b0;
    logic                 s_ready;
    logic [CMD_W-1:0]     s_command   = CMD_TICK;
    logic [ROT_W-1:0]     s_rotations = '0;
    logic                 m_valid;
    logic                 m_ready     = 1'b0;
    logic                 m_step_pulse;
    logic                 m_enable_n;
    logic [PHASE_W-1:0]   m_phase;
    logic                 m_accepted;
    logic                 cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index   = CFG_START_PERIOD;
    logic [PERIOD_W-1:0]  cfg_wdata   = '0;

    stepper_trapezoid_ramp_sequencer #(
        .TABLE_STEPS  (TABLE_STEPS),
        .HOMING_STEPS (HOMING_STEPS)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_command    (s_command),
        .s_rotations  (s_rotations),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_step_pulse (m_step_pulse),
        .m_enable_n   (m_enable_n),
        .m_phase      (m_phase),
        .m_accepted   (m_accepted),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    always #2 aclk = ~aclk;

    // profile predictor state
    logic [PERIOD_W-1:0] cfg_start;
    logic [PERIOD_W-1:0] cfg_fast;
    logic [PERIOD_W-1:0] cfg_accel;
    phase_t              ramp_phase;
    int unsigned         ramp_index;
    int unsigned         ramp_segs;
    logic [PERIOD_W-1:0] ramp_ticks;
    logic [PERIOD_W-1:0] ramp_period;
    logic                drive_off;

    result_t     predicted_outputs [$];
    dir_row_t    rows [$];
    bit          quiet        = 1'b0;
    int unsigned stall_left   = 0;
    int unsigned beats_sent   = 0;
    int unsigned pulses_seen  = 0;
    int unsigned finished_runs = 0;
    int unsigned cut_runs     = 0;
    int unsigned reg_settings = 0;
    int unsigned bad_fields   = 0;

    function automatic logic [PERIOD_W-1:0] ramp_period_at(input int unsigned i);
        longint unsigned drop;
        longint unsigned p;
        drop = i;
        drop = drop * cfg_accel;
        if (drop >= cfg_start) p = 0;
        else p = cfg_start - drop;
        if (p < cfg_fast) p = cfg_fast;
        return p[PERIOD_W-1:0];
    endfunction

    function automatic logic [PERIOD_W-1:0] step_period_for(input phase_t ph,
                                                            input int unsigned i);
        case (ph)
            PH_ACCEL:  return ramp_period_at(i);
            PH_STEADY: return cfg_fast;
            PH_DECEL:  return ramp_period_at(TABLE_STEPS - 1 - i);  // mirrored ramp
            PH_HOMING: return cfg_start;
            default:   return '0;
        endcase
    endfunction

    function automatic void park_motor();
        ramp_phase  = PH_IDLE;
        ramp_index  = 0;
        ramp_segs   = 0;
        ramp_ticks  = '0;
        ramp_period = '0;
        drive_off   = 1'b1;
    endfunction

    function automatic void load_phase(input phase_t ph);
        ramp_phase  = ph;
        ramp_index  = 0;
        ramp_ticks  = '0;
        ramp_period = step_period_for(ph, 0);
    endfunction

    function automatic bit count_tick();
        int unsigned limit;
        if (ramp_phase == PH_IDLE) return 1'b0;
        if (ramp_ticks != ramp_period) begin
            ramp_ticks = ramp_ticks + 1'b1;
            return 1'b0;
        end
        ramp_ticks = '0;
        limit = (ramp_phase == PH_HOMING) ? HOMING_STEPS : TABLE_STEPS;
        ramp_index++;
        if (ramp_index < limit) begin
            ramp_period = step_period_for(ramp_phase, ramp_index);
            return 1'b1;
        end
        // last step of a segment: the pulse still goes out
        if (ramp_phase == PH_HOMING || ramp_phase == PH_DECEL || ramp_segs == 0) begin
            park_motor();
            finished_runs++;
        end else begin
            ramp_segs--;
            load_phase(ramp_segs == 0 ? PH_DECEL : PH_STEADY);
        end
        return 1'b1;
    endfunction

    function automatic result_t predict_step_output(input cmd_t cmd,
                                                    input logic [ROT_W-1:0] rot);
        result_t r;
        r = '0;
        if (cmd == CMD_STOP) begin
            park_motor();
        end else if (cmd == CMD_START && ramp_phase == PH_IDLE && rot != 0) begin
            ramp_segs = rot * 4 - 1;
            load_phase(PH_ACCEL);
            drive_off  = 1'b0;
            r.accepted = 1'b1;
        end else if (cmd == CMD_HOMING && ramp_phase == PH_IDLE) begin
            ramp_segs = 0;
            load_phase(PH_HOMING);
            drive_off  = 1'b0;
            r.accepted = 1'b1;
        end else begin
            r.pulse = count_tick();
        end
        r.enable_n = drive_off;
        r.phase    = ramp_phase;
        return r;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(1, 2);
        return $urandom_range(3, 8);
    endfunction

    function automatic dir_row_t beat_row(input cmd_t cmd, input logic [ROT_W-1:0] rot,
                                          input int unsigned count);
        dir_row_t row;
        row.is_reg  = 1'b0;
        row.cmd     = cmd;
        row.reg_idx = CFG_UNUSED;
        row.value   = rot;
        row.count   = count;
        row.typed   = 1'b0;
        row.want    = '0;
        return row;
    endfunction

    function automatic dir_row_t known_row(input cmd_t cmd, input logic [ROT_W-1:0] rot,
                                           input int unsigned count, input logic pulse,
                                           input logic en_n, input phase_t ph,
                                           input logic acc);
        dir_row_t row;
        row = beat_row(cmd, rot, count);
        row.typed          = 1'b1;
        row.want.pulse     = pulse;
        row.want.enable_n  = en_n;
        row.want.phase     = ph;
        row.want.accepted  = acc;
        return row;
    endfunction

    function automatic dir_row_t reg_row(input cfg_idx_t idx, input logic [PERIOD_W-1:0] val);
        dir_row_t row;
        row = beat_row(CMD_TICK, val, 0);
        row.is_reg  = 1'b1;
        row.reg_idx = idx;
        return row;
    endfunction

    task automatic send_beat(input cmd_t cmd, input logic [ROT_W-1:0] rot,
                             input bit typed = 1'b0, input result_t typed_want = '0);
        int unsigned gap;
        result_t     got;
        gap = quiet ? 0 : pick_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_command   <= cmd;
        s_rotations <= rot;
        do @(posedge aclk); while (!s_ready);
        got = predict_step_output(cmd, rot);
        predicted_outputs.push_back(typed ? typed_want : got);
        beats_sent++;
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (predicted_outputs.size() != 0) @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [PERIOD_W-1:0] val,
                             input bit last);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_START_PERIOD: cfg_start = val;
            CFG_END_PERIOD:   cfg_fast  = val;
            CFG_ACCEL_STEP:   cfg_accel = val;
            default: ;
        endcase
        @(negedge aclk);
        if (last) cfg_wr_en <= 1'b0;
    endtask

    task automatic set_profile(input logic [PERIOD_W-1:0] start_p,
                               input logic [PERIOD_W-1:0] fast_p,
                               input logic [PERIOD_W-1:0] accel_p);
        drain_results();
        write_reg(CFG_START_PERIOD, start_p, 1'b0);
        write_reg(CFG_END_PERIOD, fast_p, 1'b0);
        write_reg(CFG_ACCEL_STEP, accel_p, 1'b1);
        reg_settings++;
    endtask

    // each run: a little noise, one start or homing, ticks until done or cut by stop
    task automatic run_profiles(input int unsigned runs, input bit slow);
        int unsigned      cut;
        int unsigned      n;
        int unsigned      pick;
        logic [ROT_W-1:0] rot;
        repeat (runs) begin
            quiet = ($urandom_range(0, 4) == 0);
            repeat ($urandom_range(0, 2))
                send_beat(cmd_t'($urandom_range(0, 3)),
                          $urandom_range(0, 1) ? 16'd0 : 16'($urandom));
            if (ramp_phase == PH_IDLE) begin
                pick = $urandom_range(0, 99);
                if (pick < 35) begin
                    send_beat(CMD_HOMING, 16'($urandom));
                end else begin
                    pick = $urandom_range(0, 19);
                    rot = (pick < 12) ? 16'd1 : (pick < 17) ? 16'd2 : 16'($urandom);
                    send_beat(CMD_START, rot);
                end
            end
            cut = slow ? $urandom_range(1, 20) : $urandom_range(1, 40);
            n = 0;
            while (ramp_phase != PH_IDLE && n < cut) begin
                pick = $urandom_range(0, 199);
                send_beat(pick == 0 ? CMD_START : pick == 1 ? CMD_HOMING : CMD_TICK,
                          16'($urandom));
                n++;
            end
            if (ramp_phase != PH_IDLE) begin
                send_beat(CMD_STOP, 16'($urandom));
                cut_runs++;
            end
        end
        quiet = 1'b0;
    endtask

    task automatic flag_field(input string name, input logic [PHASE_W-1:0] want_v,
                              input logic [PHASE_W-1:0] got_v);
        bad_fields++;
        $display("%0t: %s expected %0d actual %0d", $time, name, want_v, got_v);
    endtask

    // result side back-pressure
    always @(negedge aclk) begin
        if (stall_left != 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else begin
            m_ready <= 1'b1;
            stall_left = quiet ? 0 : pick_gap();
        end
    end

    always @(posedge aclk) begin : result_check
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (m_step_pulse === 1'b1) pulses_seen++;
            if (predicted_outputs.size() == 0) begin
                bad_fields++;
                $display("%0t: result beat expected none actual phase %0d",
                         $time, m_phase);
            end else begin
                want = predicted_outputs.pop_front();
                if (m_step_pulse !== want.pulse)
                    flag_field("step_pulse", PHASE_W'(want.pulse), PHASE_W'(m_step_pulse));
                if (m_enable_n !== want.enable_n)
                    flag_field("enable_n", PHASE_W'(want.enable_n), PHASE_W'(m_enable_n));
                if (m_phase !== want.phase)
                    flag_field("phase", want.phase, m_phase);
                if (m_accepted !== want.accepted)
                    flag_field("accepted", PHASE_W'(want.accepted), PHASE_W'(m_accepted));
            end
        end
    end

    initial begin
        #1_000_000;
        $display("timeout with %0d results outstanding", predicted_outputs.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : stimulus
        cfg_start = START_PERIOD_RST;
        cfg_fast  = END_PERIOD_RST;
        cfg_accel = ACCEL_STEP_RST;
        park_motor();

        // reset values, idle and busy corner cases
        rows.push_back(known_row(CMD_TICK,   16'h0000, 1,   0, 1, PH_IDLE,   0));
        rows.push_back(known_row(CMD_STOP,   16'hFFFF, 1,   0, 1, PH_IDLE,   0));
        rows.push_back(known_row(CMD_START,  16'h0000, 1,   0, 1, PH_IDLE,   0));
        rows.push_back(known_row(CMD_START,  16'hFFFF, 1,   0, 0, PH_ACCEL,  1));
        rows.push_back(known_row(CMD_TICK,   16'hFFFF, 1,   0, 0, PH_ACCEL,  0));
        rows.push_back(known_row(CMD_START,  16'h0001, 1,   0, 0, PH_ACCEL,  0));
        rows.push_back(known_row(CMD_HOMING, 16'h0000, 1,   0, 0, PH_ACCEL,  0));
        rows.push_back(known_row(CMD_STOP,   16'h0000, 1,   0, 1, PH_IDLE,   0));
        // zero periods: a pulse on every tick
        rows.push_back(reg_row(CFG_START_PERIOD, 16'h0000));
        rows.push_back(reg_row(CFG_END_PERIOD,   16'h0000));
        rows.push_back(reg_row(CFG_ACCEL_STEP,   16'h0000));
        rows.push_back(reg_row(CFG_UNUSED,       16'hFFFF));
        rows.push_back(known_row(CMD_HOMING, 16'h0005, 1,   0, 0, PH_HOMING, 1));
        rows.push_back(known_row(CMD_TICK,   16'hAAAA, 255, 1, 0, PH_HOMING, 0));
        rows.push_back(known_row(CMD_TICK,   16'h5555, 1,   1, 1, PH_IDLE,   0));
        rows.push_back(known_row(CMD_START,  16'h0001, 1,   0, 0, PH_ACCEL,  1));
        rows.push_back(known_row(CMD_TICK,   16'h0000, 255, 1, 0, PH_ACCEL,  0));
        rows.push_back(known_row(CMD_TICK,   16'h0000, 1,   1, 0, PH_STEADY, 0));
        rows.push_back(known_row(CMD_STOP,   16'h0000, 1,   0, 1, PH_IDLE,   0));
        // start period below end period
        rows.push_back(reg_row(CFG_START_PERIOD, 16'h0002));
        rows.push_back(reg_row(CFG_END_PERIOD,   16'h0005));
        rows.push_back(reg_row(CFG_ACCEL_STEP,   16'hFFFF));
        rows.push_back(beat_row(CMD_START,  16'h0003, 1));
        rows.push_back(beat_row(CMD_TICK,   16'h0000, 13));
        rows.push_back(beat_row(CMD_HOMING, 16'h0000, 1));
        rows.push_back(beat_row(CMD_STOP,   16'h0000, 1));
        // all registers at their top value
        rows.push_back(reg_row(CFG_START_PERIOD, 16'hFFFF));
        rows.push_back(reg_row(CFG_END_PERIOD,   16'hFFFF));
        rows.push_back(reg_row(CFG_ACCEL_STEP,   16'hFFFF));
        rows.push_back(beat_row(CMD_HOMING, 16'h0000, 1));
        rows.push_back(beat_row(CMD_TICK,   16'hFFFF, 4));
        rows.push_back(beat_row(CMD_STOP,   16'h0000, 1));

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int k = 0; k < rows.size(); k++) begin
            if (rows[k].is_reg) begin
                drain_results();
                write_reg(rows[k].reg_idx, rows[k].value,
                          k + 1 == rows.size() || !rows[k + 1].is_reg);
                if (k + 1 == rows.size() || !rows[k + 1].is_reg) reg_settings++;
            end else begin
                repeat (rows[k].count)
                    send_beat(rows[k].cmd, rows[k].value, rows[k].typed, rows[k].want);
            end
        end

        set_profile(16'd3, 16'd0, 16'd1);
        run_profiles(4, 1'b0);
        set_profile(16'd5, 16'd2, 16'd0);
        run_profiles(2, 1'b0);
        set_profile(16'd1, 16'd4, 16'hFFFF);
        run_profiles(2, 1'b0);
        set_profile(16'd40, 16'd1, 16'd3);
        run_profiles(2, 1'b0);
        repeat (3) begin
            set_profile(16'($urandom_range(1, 8)), 16'($urandom_range(0, 3)),
                        16'($urandom_range(0, 3)));
            run_profiles(1, 1'b0);
        end
        // slow settings: runs are always cut short by a stop
        set_profile(16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_profiles(1, 1'b1);
        set_profile(START_PERIOD_RST, END_PERIOD_RST, ACCEL_STEP_RST);
        run_profiles(1, 1'b1);

        drain_results();
        repeat (8) @(negedge aclk);

        $display("run covered %0d beats and %0d step pulses over %0d register settings",
                 beats_sent, pulses_seen, reg_settings);
        $display("%0d profiles reached their end, %0d were cut short by stop",
                 finished_runs, cut_runs);
        if (bad_fields == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d mismatching fields", bad_fields);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
